// ===== rtl/hcht_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heating curve thermostat package
// Shared types, register codes and constants.
// ----------------------------------------------------------------------------
package hcht_pkg;

    localparam int CURVE_POINTS_DEF = 6;
    localparam int TEMP_W           = 16;
    localparam int BAND_W           = 12;
    localparam int POINT_W          = 32;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 32;
    localparam int POS_W            = 7;
    localparam int PROD_W           = 2 * TEMP_W;
    localparam int DIV_STEPS        = TEMP_W;
    localparam int DIV_CNT_W        = $clog2(DIV_STEPS + 1);

    localparam logic signed [TEMP_W-1:0] TARGET_RESET = 16'sd6400;
    localparam logic [BAND_W-1:0]        BAND_RESET   = 12'd256;
    localparam logic [POS_W-1:0]         OPEN_POS     = 7'd100;
    localparam logic [POS_W-1:0]         CLOSED_POS   = 7'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE = 3'd0,
        REG_BAND   = 3'd1,
        REG_CURVE0 = 3'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_MUL,
        ST_DSTART,
        ST_DWAIT,
        ST_FIX,
        ST_HYST,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] outdoor_temp;
        logic signed [TEMP_W-1:0] supply_temp;
        logic                     link_up;
    } in_data_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] target_temp;
        logic                     write_valid;
        logic [POS_W-1:0]         valve_position;
    } out_data_t;

    typedef struct packed {
        logic              enable;
        logic [BAND_W-1:0] band;
    } cfg_t;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [TEMP_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [TEMP_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== rtl/hcht_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heating curve thermostat configuration registers
// Enable, dead band half-width and the heating curve points.
// ----------------------------------------------------------------------------
module hcht_cfg
    import hcht_pkg::*;
#(
    parameter int CURVE_POINTS = CURVE_POINTS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [CFG_IDX_W-1:0]                 cfg_index,
    input  logic [CFG_DATA_W-1:0]                cfg_data,
    output cfg_t                                 cfg,
    output logic [CURVE_POINTS-1:0][POINT_W-1:0] curve_pt
);

    cfg_t                                 cfg_reg;
    logic [CURVE_POINTS-1:0][POINT_W-1:0] curve_pt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable <= 1'b0;
            cfg_reg.band   <= BAND_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_ENABLE)
                cfg_reg.enable <= cfg_data[0];
            if (cfg_index == REG_BAND)
                cfg_reg.band <= cfg_data[BAND_W-1:0];
        end
    end

    for (genvar k = 0; k < CURVE_POINTS; k++)
    begin : g_pt
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                curve_pt_reg[k] <= '0;
            else if (cfg_we && (cfg_index == CFG_IDX_W'(int'(REG_CURVE0) + k)))
                curve_pt_reg[k] <= cfg_data[POINT_W-1:0];
        end
    end

    assign cfg      = cfg_reg;
    assign curve_pt = curve_pt_reg;

endmodule

// ===== rtl/hcht_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heating curve thermostat divider
// Restoring unsigned divider, one quotient bit per cycle; the quotient is
// known to fit in TEMP_W bits.
// ----------------------------------------------------------------------------
module hcht_div
    import hcht_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [TEMP_W-1:0]    rem_reg, rem_next;
    logic [TEMP_W-1:0]    quo_reg, quo_next;
    logic [TEMP_W-1:0]    dvs_reg, dvs_next;
    logic [TEMP_W:0]      cand;
    logic [TEMP_W+1:0]    diff;
    logic                 ge;

    always_comb
    begin
        cand      = {rem_reg, quo_reg[TEMP_W-1]};
        diff      = {1'b0, cand} - {2'b00, dvs_reg};
        ge        = !diff[TEMP_W+1];
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            cnt_next = DIV_CNT_W'(DIV_STEPS);
            rem_next = req.dividend[PROD_W-1:TEMP_W];
            quo_next = req.dividend[TEMP_W-1:0];
            dvs_next = req.divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == DIV_CNT_W'(1));
            rem_next  = ge ? diff[TEMP_W-1:0] : cand[TEMP_W-1:0];
            quo_next  = {quo_reg[TEMP_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== rtl/hcht_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heating curve thermostat sequencer
// Segment search, interpolation through the divider, hysteresis and
// the output register.
// ----------------------------------------------------------------------------
module hcht_ctrl
    import hcht_pkg::*;
#(
    parameter int CURVE_POINTS = CURVE_POINTS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  in_data_t                             in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output out_data_t                            out_data,
    input  cfg_t                                 cfg,
    input  logic [CURVE_POINTS-1:0][POINT_W-1:0] curve_pt,
    output div_req_t                             div_req,
    input  div_rsp_t                             div_rsp
);

    localparam int SEG_W = $clog2(CURVE_POINTS);

    ctrl_state_t              state_reg, state_next;
    logic [SEG_W-1:0]         seg_reg, seg_next;
    logic signed [TEMP_W-1:0] tgt_reg, tgt_next;
    logic                     valve_reg, valve_next;
    logic                     write_reg, write_next;
    logic                     out_valid_reg, out_valid_next;
    out_data_t                out_data_reg, out_data_next;

    logic signed [TEMP_W-1:0] x_reg, x_next;
    logic signed [TEMP_W-1:0] s_reg, s_next;
    logic signed [TEMP_W-1:0] x1_reg, x1_next;
    logic signed [TEMP_W-1:0] y1_reg, y1_next;
    logic [TEMP_W-1:0]        dymag_reg, dymag_next;
    logic [TEMP_W-1:0]        xoff_reg, xoff_next;
    logic [TEMP_W-1:0]        dx_reg, dx_next;
    logic                     neg_reg, neg_next;
    logic [PROD_W-1:0]        prod_reg, prod_next;

    logic [SEG_W-1:0]         seg_inc;
    logic [POINT_W-1:0]       pt_k1;
    logic signed [TEMP_W-1:0] x2, y2, x0, y0, ylast;
    logic signed [TEMP_W:0]   dx17, dy17, xo17, q17, sum17;
    logic                     hit;
    logic signed [TEMP_W+1:0] lo18, hi18, s18;

    always_comb
    begin
        seg_inc = seg_reg + SEG_W'(1);
        pt_k1   = curve_pt[seg_inc];
        x2      = signed'(pt_k1[POINT_W-1:TEMP_W]);
        y2      = signed'(pt_k1[TEMP_W-1:0]);
        x0      = signed'(curve_pt[0][POINT_W-1:TEMP_W]);
        y0      = signed'(curve_pt[0][TEMP_W-1:0]);
        ylast   = signed'(curve_pt[CURVE_POINTS-1][TEMP_W-1:0]);
        hit     = (x_reg >= x1_reg) && (x_reg <= x2);
        dx17    = {x2[TEMP_W-1], x2} - {x1_reg[TEMP_W-1], x1_reg};
        dy17    = {y2[TEMP_W-1], y2} - {y1_reg[TEMP_W-1], y1_reg};
        xo17    = {x_reg[TEMP_W-1], x_reg} - {x1_reg[TEMP_W-1], x1_reg};
        q17     = neg_reg ? -signed'({1'b0, div_rsp.quotient})
                          : signed'({1'b0, div_rsp.quotient});
        sum17   = {y1_reg[TEMP_W-1], y1_reg} + q17;
        s18     = {{2{s_reg[TEMP_W-1]}}, s_reg};
        lo18    = {{2{tgt_reg[TEMP_W-1]}}, tgt_reg} - signed'({6'd0, cfg.band});
        hi18    = {{2{tgt_reg[TEMP_W-1]}}, tgt_reg} + signed'({6'd0, cfg.band});

        state_next     = state_reg;
        seg_next       = seg_reg;
        tgt_next       = tgt_reg;
        valve_next     = valve_reg;
        write_next     = write_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        x_next         = x_reg;
        s_next         = s_reg;
        x1_next        = x1_reg;
        y1_next        = y1_reg;
        dymag_next     = dymag_reg;
        xoff_next      = xoff_reg;
        dx_next        = dx_reg;
        neg_next       = neg_reg;
        prod_next      = prod_reg;
        div_req.start    = 1'b0;
        div_req.dividend = prod_reg;
        div_req.divisor  = dx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    write_next = 1'b0;
                    x_next     = in_data.outdoor_temp;
                    s_next     = in_data.supply_temp;
                    x1_next    = x0;
                    y1_next    = y0;
                    seg_next   = '0;
                    if (cfg.enable && in_data.link_up)
                        state_next = ST_SEARCH;
                    else
                        state_next = ST_OUT;
                end
            end
            ST_SEARCH:
            begin
                if (hit)
                begin
                    dx_next    = dx17[TEMP_W-1:0];
                    xoff_next  = xo17[TEMP_W-1:0];
                    neg_next   = dy17[TEMP_W];
                    dymag_next = dy17[TEMP_W] ? TEMP_W'(-dy17) : dy17[TEMP_W-1:0];
                    if (dx17 == '0)
                    begin
                        tgt_next   = y1_reg;
                        state_next = ST_HYST;
                    end
                    else
                        state_next = ST_MUL;
                end
                else if (seg_reg == SEG_W'(CURVE_POINTS - 2))
                begin
                    tgt_next   = (x_reg < x0) ? y0 : ylast;
                    state_next = ST_HYST;
                end
                else
                begin
                    x1_next  = x2;
                    y1_next  = y2;
                    seg_next = seg_inc;
                end
            end
            ST_MUL:
            begin
                prod_next  = dymag_reg * xoff_reg;
                state_next = ST_DSTART;
            end
            ST_DSTART:
            begin
                div_req.start = 1'b1;
                state_next    = ST_DWAIT;
            end
            ST_DWAIT:
            begin
                if (div_rsp.done)
                    state_next = ST_FIX;
            end
            ST_FIX:
            begin
                tgt_next   = sum17[TEMP_W-1:0];
                state_next = ST_HYST;
            end
            ST_HYST:
            begin
                if (s18 < lo18)
                begin
                    valve_next = 1'b1;
                    write_next = !valve_reg;
                end
                else if (s18 > hi18)
                begin
                    valve_next = 1'b0;
                    write_next = valve_reg;
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next               = 1'b1;
                    out_data_next.target_temp    = tgt_reg;
                    out_data_next.write_valid    = write_reg;
                    out_data_next.valve_position = valve_reg ? OPEN_POS : CLOSED_POS;
                    state_next                   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seg_reg       <= '0;
            tgt_reg       <= TARGET_RESET;
            valve_reg     <= 1'b0;
            write_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seg_reg       <= seg_next;
            tgt_reg       <= tgt_next;
            valve_reg     <= valve_next;
            write_reg     <= write_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        x_reg        <= x_next;
        s_reg        <= s_next;
        x1_reg       <= x1_next;
        y1_reg       <= y1_next;
        dymag_reg    <= dymag_next;
        xoff_reg     <= xoff_next;
        dx_reg       <= dx_next;
        neg_reg      <= neg_next;
        prod_reg     <= prod_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/heating_curve_hysteresis_thermostat_core.sv =====
`timescale 1ns / 1ps
// When disabled or link down, the accepted beat goes straight to the output register;
// otherwise the curve is searched and interpolated first.
// One beat at a time, next input taken once the output loads: the search
// steps through the segments in turn, then the divider runs until done;
// input stalls meanwhile. Reset (async, active low): target 25.0 degrees,
// valve closed, enable 0, band 1.0 degree, curve points 0, no beat pending.
// ----------------------------------------------------------------------------
// Heating curve thermostat core
// Weather compensated supply target with hysteresis valve control.
// ----------------------------------------------------------------------------
module heating_curve_hysteresis_thermostat_core
    import hcht_pkg::*;
#(
    parameter int CURVE_POINTS = CURVE_POINTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_data_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_data_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t                                 cfg;
    logic [CURVE_POINTS-1:0][POINT_W-1:0] curve_pt;
    div_req_t                             div_req;
    div_rsp_t                             div_rsp;

    hcht_cfg #(
        .CURVE_POINTS (CURVE_POINTS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .curve_pt  (curve_pt)
    );

    hcht_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    hcht_ctrl #(
        .CURVE_POINTS (CURVE_POINTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg       (cfg),
        .curve_pt  (curve_pt),
        .div_req   (div_req),
        .div_rsp   (div_rsp)
    );

endmodule

// ===== rtl/hcht_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heating curve thermostat port checker
// Port level properties of the core, bound to the top level.
// ----------------------------------------------------------------------------
module hcht_checker
    import hcht_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input in_data_t  in_data,
    input logic      out_valid,
    input logic      out_stall,
    input out_data_t out_data
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_data))
        else $error("input beat changed while stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second beat taken while busy");

    a_valve_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.valve_position == OPEN_POS)
                   || (out_data.valve_position == CLOSED_POS))
        else $error("valve position not fully open or closed");

    a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_valid |=> !out_valid)
        else $error("output beat before the item was processed");

endmodule

bind heating_curve_hysteresis_thermostat_core hcht_checker u_hcht_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heating curve thermostat testbench
// Streams temperature samples into the core under random valid and stall
// bursts and predicts every output beat from a behavioral copy of the curve
// lookup and the hysteresis rule. Beats are checked in order, field by field.
// Directed corners come first, then random curves, bands and samples over
// several register settings.
// ----------------------------------------------------------------------------
module tb;
    import hcht_pkg::*;

    localparam int NPTS        = CURVE_POINTS_DEF;
    localparam int CYCLE_LIMIT = 1000000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_data_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_data_t             out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // register file and core state as the predictor sees them
    logic                     en_cfg        = 1'b0;
    logic [BAND_W-1:0]        band_cfg      = BAND_RESET;
    logic [POINT_W-1:0]       curve_pts [NPTS] = '{default: '0};
    logic signed [TEMP_W-1:0] hold_target   = TARGET_RESET;
    logic                     valve_is_open = 1'b0;

    int        cx [NPTS];
    int        cy [NPTS];
    in_data_t  sample_q [$];
    out_data_t valve_q [$];
    out_data_t due;
    int        n_sent;
    int        n_done;
    int        n_bad;
    int        n_cmds;
    int        n_settings = 1;
    int        cycles;
    int        in_gap;
    int        out_gap;
    bit        idle_on = 1'b1;

    heating_curve_hysteresis_thermostat_core i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int px(int k);
        return $signed(curve_pts[k][31:16]);
    endfunction

    function automatic int py(int k);
        return $signed(curve_pts[k][15:0]);
    endfunction

    function automatic int heating_curve(int x);
        longint q;
        for (int k = 0; k < NPTS - 1; k++)
        begin
            if (x >= px(k) && x <= px(k + 1))
            begin
                if (px(k + 1) == px(k))
                    return py(k);
                q = longint'(py(k + 1) - py(k)) * longint'(x - px(k))
                    / longint'(px(k + 1) - px(k));
                return py(k) + int'(q);
            end
        end
        if (x < px(0))
            return py(0);
        return py(NPTS - 1);
    endfunction

    function automatic out_data_t advance_thermostat(in_data_t d);
        out_data_t r;
        int        s;
        int        t;
        int        b;
        r = '0;
        if (en_cfg && d.link_up)
        begin
            hold_target = TEMP_W'(heating_curve(d.outdoor_temp));
            s = d.supply_temp;
            t = hold_target;
            b = int'(band_cfg);
            if (s < t - b)
            begin
                if (!valve_is_open)
                begin
                    valve_is_open = 1'b1;
                    r.write_valid = 1'b1;
                end
            end
            else if (s > t + b)
            begin
                if (valve_is_open)
                begin
                    valve_is_open = 1'b0;
                    r.write_valid = 1'b1;
                end
            end
        end
        r.target_temp    = hold_target;
        r.valve_position = valve_is_open ? OPEN_POS : CLOSED_POS;
        return r;
    endfunction

    function automatic int rand16();
        logic [15:0] v;
        v = 16'($urandom);
        return $signed(v);
    endfunction

    function automatic int clip16(int v);
        return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
    endfunction

    task automatic send(int x, int s, bit up);
        in_data_t d;
        d.outdoor_temp = TEMP_W'(x);
        d.supply_temp  = TEMP_W'(s);
        d.link_up      = up;
        sample_q.push_back(d);
        n_sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_ENABLE)
            en_cfg = val[0];
        else if (idx == REG_BAND)
            band_cfg = val[BAND_W-1:0];
        else
            curve_pts[idx - REG_CURVE0] = val;
    endtask

    // writes every register; the curve comes from cx/cy
    task automatic configure(bit en, int band);
        write_reg(REG_ENABLE, CFG_DATA_W'(en));
        write_reg(REG_BAND, CFG_DATA_W'(band));
        for (int k = 0; k < NPTS; k++)
            write_reg(CFG_IDX_W'(REG_CURVE0 + k), {TEMP_W'(cx[k]), TEMP_W'(cy[k])});
        @(posedge clk);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic settle();
        while (n_done < n_sent)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // sample driver
    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
            valve_q.push_back(advance_thermostat(in_data));
        if (!(in_valid && in_stall))
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (sample_q.size() > 0)
            begin
                in_valid <= 1'b1;
                in_data  <= sample_q.pop_front();
                if (idle_on && $urandom_range(0, 5) == 0)
                    in_gap = $urandom_range(1, 16);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            n_done++;
            if (valve_q.size() == 0)
            begin
                n_bad++;
                if (n_bad <= 10)
                    $display("%0t: beat with none pending: target %0d write %0b valve %0d",
                             $time, out_data.target_temp, out_data.write_valid,
                             out_data.valve_position);
            end
            else
            begin
                due = valve_q.pop_front();
                if (out_data.write_valid)
                    n_cmds++;
                if (out_data.target_temp !== due.target_temp
                    || out_data.write_valid !== due.write_valid
                    || out_data.valve_position !== due.valve_position)
                begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("%0t: mismatch exp target %0d write %0b valve %0d, got %0d %0b %0d",
                                 $time, due.target_temp, due.write_valid, due.valve_position,
                                 out_data.target_temp, out_data.write_valid,
                                 out_data.valve_position);
                end
            end
        end
        if (out_gap > 0)
        begin
            out_gap--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (idle_on && $urandom_range(0, 7) == 0)
                out_gap = $urandom_range(1, 16);
        end
    end

    initial
    begin
        int mode;
        int n_items;
        int band;
        int r;
        int k;
        int x;
        int s;
        int t;
        int b;
        int tmp;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // still disabled out of reset
        send(0, 0, 1'b1);
        send(-32768, 32767, 1'b1);
        settle();

        // zero-width first segment, falling curve
        cx = '{-5120, -5120, -2560, 0, 2560, 5120};
        cy = '{19200, 17920, 15360, 12800, 10000, 6400};
        configure(1'b1, 256);
        send(-32768, -32768, 1'b1);     // below the curve, opens
        send(32767, 32767, 1'b1);       // above the curve, closes
        send(-5120, 19200 - 256, 1'b1); // on the lower band edge
        send(-5120, 19200 - 257, 1'b1);
        send(-5120, 19200 + 256, 1'b1);
        send(-5120, 19200 + 257, 1'b1);
        send(1, 0, 1'b1);               // quotient truncates toward zero
        send(0, 32767, 1'b0);           // link down
        send(0, 32767, 1'b1);
        send(-3840, 0, 1'b1);
        send(3000, -1, 1'b1);
        settle();

        // descending first segment, no band
        cx = '{0, -2560, 2560, 2560, 2560, 2560};
        cy = '{5000, 6000, 7000, 7000, 7000, -7000};
        configure(1'b1, 0);
        send(1000, 6695, 1'b1);
        send(1000, 6696, 1'b1);
        send(-3000, 4999, 1'b1);
        send(3000, -6999, 1'b1);
        settle();

        configure(1'b1, 2560);
        send(3000, -7000 - 2561, 1'b1);
        send(3000, -7000 + 2560, 1'b1);
        settle();

        for (int ph = 0; ph < 8; ph++)
        begin
            mode = (ph == 1 || ph == 6) ? 0 : (ph == 2) ? 3 : (ph == 4) ? 2 : 1;
            case (mode)
                0:
                begin
                    for (int i = 0; i < NPTS; i++)
                    begin
                        cx[i] = rand16();
                        cy[i] = rand16();
                    end
                end
                1:
                begin
                    cx[0] = -256 * int'($urandom_range(15, 35));
                    cy[0] = 256 * int'($urandom_range(50, 80));
                    for (int i = 1; i < NPTS; i++)
                    begin
                        cx[i] = cx[i - 1] + int'($urandom_range(0, 15 * 256));
                        cy[i] = cy[i - 1] - int'($urandom_range(0, 10 * 256));
                    end
                end
                2:
                begin
                    for (int i = 0; i < NPTS; i++)
                    begin
                        cx[i] = rand16();
                        cy[i] = rand16();
                    end
                end
                default:
                begin
                    for (int i = 0; i < NPTS; i++)
                    begin
                        cx[i] = 512 * int'($urandom_range(0, 2)) - 512;
                        cy[i] = rand16();
                    end
                end
            endcase
            if (mode == 0 || mode == 3)
            begin
                for (int i = 0; i < NPTS - 1; i++)
                    for (int j = 0; j < NPTS - 1 - i; j++)
                        if (cx[j] > cx[j + 1])
                        begin
                            tmp       = cx[j];
                            cx[j]     = cx[j + 1];
                            cx[j + 1] = tmp;
                        end
            end
            if (ph == 1)
            begin
                cx[0]        = -32768;
                cy[0]        = -32768;
                cx[NPTS - 1] = 32767;
                cy[NPTS - 1] = 32767;
            end
            band = (ph == 0) ? 0 : (ph == 1) ? 2560 : int'($urandom_range(0, 2560));
            idle_on = (ph != 5 && ph != 7);
            configure(ph != 3, band);

            n_items = (ph == 3) ? 40 : 245;
            for (int i = 0; i < n_items; i++)
            begin
                r = $urandom_range(0, 99);
                k = $urandom_range(0, NPTS - 1);
                if (r < 70)
                    x = clip16(cx[k] + int'($urandom_range(0, 1024)) - 512);
                else if (r < 90)
                    x = rand16();
                else
                    x = $urandom_range(0, 1) ? 32767 : -32768;
                t = heating_curve(x);
                b = int'(band_cfg);
                r = $urandom_range(0, 99);
                if (r < 70)
                    s = clip16(t + int'($urandom_range(0, 2 * b + 600)) - b - 300);
                else if (r < 85)
                    s = rand16();
                else
                begin
                    case ($urandom_range(0, 3))
                        0:       s = t - b - 1;
                        1:       s = t - b;
                        2:       s = t + b;
                        default: s = t + b + 1;
                    endcase
                    s = clip16(s);
                end
                send(x, s, $urandom_range(0, 9) != 0);
            end
            settle();
        end

        repeat (40) @(posedge clk);
        $display("Ran %0d samples over %0d register settings: directed corners, then random curves.",
                 n_sent, n_settings);
        $display("Checked %0d result beats with %0d valve commands; %0d bad, %0d never arrived.",
                 n_done, n_cmds, n_bad, valve_q.size());
        if (n_bad == 0 && valve_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
